/* hdl/svm_pkg.sv */
package svm_pkg;

   localparam int FeatWidth  = 16;
   localparam int DistWidth  = 17;
   localparam int SqWidth    = 36;
   localparam int TermWidth  = 34;
   localparam int OutWidth   = 32;
   localparam int KernWidth  = 17;
   localparam int GammaWidth = 16;
   localparam int CountWidth = 7;

   localparam logic [1:0] REQ_SV_FEAT  = 2'd0;
   localparam logic [1:0] REQ_COEF     = 2'd1;
   localparam logic [1:0] REQ_SAMPLE   = 2'd2;

   localparam logic [17:0] Log2eQ16 = 18'd94548;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // Row control travelling down the distance cells
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   // Return 2^(-i/16) in Q1.16 for i in 0..16
   function automatic logic [16:0] pow2_neg(input logic [4:0] i);
      logic [16:0] t;
      unique case (i)
         5'd0:  t = 17'd65536;
         5'd1:  t = 17'd62757;
         5'd2:  t = 17'd60097;
         5'd3:  t = 17'd57549;
         5'd4:  t = 17'd55109;
         5'd5:  t = 17'd52773;
         5'd6:  t = 17'd50535;
         5'd7:  t = 17'd48393;
         5'd8:  t = 17'd46341;
         5'd9:  t = 17'd44376;
         5'd10: t = 17'd42495;
         5'd11: t = 17'd40693;
         5'd12: t = 17'd38968;
         5'd13: t = 17'd37316;
         5'd14: t = 17'd35734;
         5'd15: t = 17'd34219;
         default: t = 17'd32768;
      endcase
      return t;
   endfunction

endpackage

/* hdl/svm_ram.sv */
module svm_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one entry, read one registered entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/svm_cell.sv */
// One feature cell: squares the distance of its feature and adds the
// partial sum handed over from the left neighbor.
module svm_cell
   import svm_pkg::*;
(
   input  logic                        clock,
   input  logic signed [FeatWidth-1:0] sv_feat,
   input  logic signed [FeatWidth-1:0] x_feat,
   input  logic [SqWidth-1:0]          sum_left,
   output logic [SqWidth-1:0]          sum_right
);

   logic signed [DistWidth-1:0] d;
   logic [DistWidth-1:0]        m;
   logic [2*DistWidth-1:0]      sq;
   logic [SqWidth-1:0]          sum_ff;
   logic [SqWidth-1:0]          sum_in;

   // Absolute distance, square, accumulate
   always_comb begin
      d      = DistWidth'(sv_feat) - DistWidth'(x_feat);
      m      = d[DistWidth-1] ? DistWidth'(-d) : DistWidth'(d);
      sq     = m * m;
      sum_in = sum_left + SqWidth'(sq);
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum_right = sum_ff;

endmodule

/* hdl/svm_kernel.sv */
// Kernel back end: gamma scale, log2(e) scale, table interpolation, shift,
// coefficient product. Each stage registered.
module svm_kernel
   import svm_pkg::*;
(
   input  logic                         clock,
   input  logic [GammaWidth-1:0]        gamma,
   input  logic [SqWidth-1:0]           dist_sq,
   input  logic signed [FeatWidth-1:0]  coef,
   output logic signed [TermWidth-1:0]  term
);

   logic [SqWidth+GammaWidth-1:0] ga_full;
   logic [SqWidth-1:0]            a_ff;
   logic signed [FeatWidth-1:0]   coef1_ff, coef2_ff, coef3_ff, coef4_ff;
   logic [SqWidth+17:0]           y_full;
   logic [37:0]                   y_ff;
   logic [3:0]                    idx;
   logic [11:0]                   r;
   logic [16:0]                   t0, t1, step, p;
   logic [28:0]                   prod;
   logic [16:0]                   p_ff;
   logic [21:0]                   k_ff;
   logic [KernWidth-1:0]          e_ff;
   logic signed [TermWidth-1:0]   term_ff;

   assign ga_full = dist_sq * gamma;
   assign y_full  = a_ff * Log2eQ16;

   // Interpolate the fractional power of two
   always_comb begin
      idx  = y_ff[15:12];
      r    = y_ff[11:0];
      t0   = pow2_neg({1'b0, idx});
      t1   = pow2_neg({1'b0, idx} + 5'd1);
      step = t0 - t1;
      prod = 29'(step) * 29'(r) + 29'd2048;
      p    = t0 - 17'(prod >> 12);
   end

   always_ff @(posedge clock) begin
      a_ff     <= SqWidth'(ga_full >> 16);
      coef1_ff <= coef;
      y_ff     <= 38'(y_full >> 16);
      coef2_ff <= coef1_ff;
      p_ff     <= p;
      k_ff     <= y_ff[37:16];
      coef3_ff <= coef2_ff;
      e_ff     <= (k_ff >= 22'd17) ? '0 : (p_ff >> k_ff[4:0]);
      coef4_ff <= coef3_ff;
      term_ff  <= TermWidth'(coef4_ff) * TermWidth'(signed'({1'b0, e_ff}));
   end

   assign term = term_ff;

endmodule

/* hdl/svm_rbf_decision_value_core.sv */
// Channel | Direction | Content
// req_*   | in        | req_type, req_vector_index, req_feature_index, req_value
// rsp_*   | out       | rsp_decision (Q16.16 signed, saturated)
// csr     | in/out    | gamma (addr 0), sv_count (addr 4)
// Loads and non-final sample features leave the core idle and ready.
// The final sample feature holds the request side through the run, drain and
// output states; one support vector enters the cell row per cycle.
// Reset clears control and presets gamma and sv_count; stores hold garbage until written.
// The result waits in an output register while requests keep flowing; a sum
// that finishes while an earlier result still waits holds until it leaves.
module svm_rbf_decision_value_core
   import svm_pkg::*;
#(
   parameter int NUM_SV   = 64,
   parameter int NUM_FEAT = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [5:0]           req_vector_index,
   input  logic [3:0]           req_feature_index,
   input  logic signed [15:0]   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_decision,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int SvBits   = (NUM_SV > 1) ? $clog2(NUM_SV) : 1;
   localparam int FeatBits = (NUM_FEAT > 1) ? $clog2(NUM_FEAT) : 1;
   localparam int RowBits  = FeatBits + SvBits;
   localparam int CntBits  = SvBits + 1;
   localparam int Latency  = NUM_FEAT + 6;
   localparam int AccWidth = 48;

   state_type state_ff, state_in;

   logic [GammaWidth-1:0] gamma_ff;
   logic [CountWidth-1:0] count_ff;
   logic accept;
   logic [CntBits-1:0] n_sv;
   logic [CntBits-1:0] issue_ff, issue_in;
   logic [CntBits:0]   drain_ff, drain_in;
   tag_type            tag_ff [Latency];
   logic signed [FeatWidth-1:0] sample_ff [NUM_FEAT];
   logic signed [FeatWidth-1:0] sv_rd [NUM_FEAT];
   logic signed [FeatWidth-1:0] coef_rd;
   logic signed [FeatWidth-1:0] coef_dly_ff [NUM_FEAT];
   logic [SqWidth-1:0]          chain [NUM_FEAT+1];
   logic signed [TermWidth-1:0] term;
   logic signed [AccWidth-1:0]  acc_ff, acc_in;
   logic signed [31:0]          decision_ff;
   logic                        rsp_valid_ff;
   logic                        out_load;
   logic signed [AccWidth-1:0]  q;
   logic                        in_range_sv, in_range_ft;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {16'd0, gamma_ff} : {25'd0, count_ff};

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= 16'd3277;
         count_ff <= 7'd64;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == 1'b0) begin
            gamma_ff <= pwdata[15:0];
         end else begin
            count_ff <= pwdata[6:0];
         end
      end
   end

   assign n_sv = (32'(count_ff) > NUM_SV) ? CntBits'(NUM_SV) :
                 CntBits'(count_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range_sv = (32'(req_vector_index) < NUM_SV);
   assign in_range_ft = (32'(req_feature_index) < NUM_FEAT);

   // Hold the sample features
   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_FEAT; j++) begin
         if (accept && req_type == REQ_SAMPLE && in_range_ft &&
             FeatBits'(req_feature_index) == FeatBits'(j)) begin
            sample_ff[j] <= req_value;
         end
      end
   end

   // One memory per feature column, one for coefficients
   for (genvar j = 0; j < NUM_FEAT; j++) begin : g_col
      svm_ram #(.Width(FeatWidth), .Depth(1 << SvBits)) u_sv (
         .clock   (clock),
         .wr_en   (accept && req_type == REQ_SV_FEAT && in_range_sv && in_range_ft &&
                   FeatBits'(req_feature_index) == FeatBits'(j)),
         .wr_addr (SvBits'(req_vector_index)),
         .wr_data (req_value),
         .rd_addr (issue_ff[SvBits-1:0]),
         .rd_data (sv_rd[j])
      );
   end

   svm_ram #(.Width(FeatWidth), .Depth(1 << SvBits)) u_coef (
      .clock   (clock),
      .wr_en   (accept && req_type == REQ_COEF && in_range_sv),
      .wr_addr (SvBits'(req_vector_index)),
      .wr_data (req_value),
      .rd_addr (issue_ff[SvBits-1:0]),
      .rd_data (coef_rd)
   );

   // Cell row: cell j sees its column through j skew registers
   logic signed [FeatWidth-1:0] sv_skew [NUM_FEAT][NUM_FEAT];
   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_FEAT; j++) begin
         sv_skew[j][0] <= sv_rd[j];
         for (int s = 1; s < NUM_FEAT; s++) begin
            sv_skew[j][s] <= sv_skew[j][s-1];
         end
      end
      coef_dly_ff[0] <= coef_rd;
      for (int s = 1; s < NUM_FEAT; s++) begin
         coef_dly_ff[s] <= coef_dly_ff[s-1];
      end
   end

   assign chain[0] = '0;
   for (genvar j = 0; j < NUM_FEAT; j++) begin : g_cell
      svm_cell u_cell (
         .clock     (clock),
         .sv_feat   (j == 0 ? sv_rd[j] : sv_skew[j][(j > 0 ? j - 1 : 0)]),
         .x_feat    (sample_ff[j]),
         .sum_left  (chain[j]),
         .sum_right (chain[j+1])
      );
   end

   svm_kernel u_kernel (
      .clock   (clock),
      .gamma   (gamma_ff),
      .dist_sq (chain[NUM_FEAT]),
      .coef    (coef_dly_ff[NUM_FEAT-1]),
      .term    (term)
   );

   // Valid tags: read (1) + cells (NUM_FEAT) + kernel (5)
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Latency; s++) begin
            tag_ff[s] <= '0;
         end
      end else begin
         tag_ff[0].valid <= (state_ff == ST_RUN) && (issue_ff < n_sv);
         tag_ff[0].last  <= 1'b0;
         for (int s = 1; s < Latency; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   // Move the finished sum into the output register once it is free
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      drain_in = drain_ff;
      acc_in   = acc_ff;
      if (tag_ff[Latency-1].valid) begin
         acc_in = acc_ff + AccWidth'(term);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_SAMPLE && in_range_ft &&
                32'(req_feature_index) == NUM_FEAT - 1) begin
               state_in = ST_RUN;
               issue_in = '0;
               acc_in   = '0;
            end
         end
         ST_RUN: begin
            if (issue_ff < n_sv) begin
               issue_in = issue_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
               drain_in = '0;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (32'(drain_ff) == Latency) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         drain_ff <= drain_in;
      end
      acc_ff <= acc_in;
   end

   // Floor to Q16.16 and saturate
   always_comb begin
      q = acc_ff >>> 8;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (q > 48'sh0000_7FFF_FFFF) begin
            decision_ff <= 32'h7FFF_FFFF;
         end else if (q < -48'sh0000_8000_0000) begin
            decision_ff <= 32'h8000_0000;
         end else begin
            decision_ff <= q[31:0];
         end
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_decision = decision_ff;

   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");
   a_no_tag_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> !tag_ff[Latency-1].valid)
      else $error("term arrived after result");
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_ff <= n_sv || state_ff != ST_RUN)
      else $error("issue counter overran");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_decision)))
      else $error("result dropped or changed while waiting");

endmodule

/* tb/svm_rbf_decision_value_checker.sv */
module svm_rbf_decision_value_checker
   import svm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [5:0]         req_vector_index,
   input  logic [3:0]         req_feature_index,
   input  logic signed [15:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_decision,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumVec  = 64;
   localparam int NumFeat = 4;
   localparam logic [2:0] AddrGamma   = 3'd0;
   localparam logic [2:0] AddrSvCount = 3'd4;
   localparam longint Log2e = 94548;

   logic signed [15:0] vec_mem [NumVec][NumFeat];
   logic signed [15:0] coef_mem [NumVec];
   logic signed [15:0] sample_mem [NumFeat];
   logic [15:0]        gamma_reg;
   logic [6:0]         count_reg;
   logic signed [31:0] decision_queue [$];

   // 2^(-i/16) in Q1.16
   function automatic longint exp2_step(input int i);
      longint steps [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                             48393, 46341, 44376, 42495, 40693, 38968, 37316,
                             35734, 34219, 32768};
      return steps[i];
   endfunction

   // exp(-gamma * |sv - x|^2) for one stored vector, Q1.16
   function automatic longint kernel_value(input int v);
      longint dist_sq, arg, y, k, f, r, p;
      int     i;
      dist_sq = 0;
      for (int j = 0; j < NumFeat; j++) begin
         longint d;
         d = longint'(vec_mem[v][j]) - longint'(sample_mem[j]);
         dist_sq += d * d;
      end
      arg = (longint'(gamma_reg) * dist_sq) >> 16;
      y = (arg * Log2e) >> 16;
      k = y >> 16;
      f = y & 64'hFFFF;
      i = int'(f >> 12);
      r = f & 64'hFFF;
      p = exp2_step(i) - (((exp2_step(i) - exp2_step(i + 1)) * r + 2048) >> 12);
      if (k >= 17)
         return 0;
      return p >> k;
   endfunction

   // Weighted kernel sum, floored to Q16.16 and saturated
   function automatic logic signed [31:0] decision_of_sample();
      longint acc, q;
      int     n;
      acc = 0;
      n = (count_reg > NumVec) ? NumVec : int'(count_reg);
      for (int v = 0; v < n; v++)
         acc += longint'(coef_mem[v]) * kernel_value(v);
      q = acc >>> 8;
      if (q > 64'sd2147483647)
         q = 64'sd2147483647;
      if (q < -64'sd2147483648)
         q = -64'sd2147483648;
      return q[31:0];
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         gamma_reg <= 16'd3277;
         count_reg <= 7'd64;
         decision_queue.delete();
      end else begin
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            if (paddr == AddrGamma)
               gamma_reg <= pwdata[15:0];
            else if (paddr == AddrSvCount)
               count_reg <= pwdata[6:0];
         end
         // Update stores on each accepted request; predict on each final sample feature
         if (req_valid && req_ready) begin
            if (req_type == REQ_SV_FEAT) begin
               if (req_feature_index < NumFeat)
                  vec_mem[req_vector_index][req_feature_index[1:0]] = req_value;
            end else if (req_type == REQ_COEF) begin
               coef_mem[req_vector_index] = req_value;
            end else if (req_type == REQ_SAMPLE && req_feature_index < NumFeat) begin
               sample_mem[req_feature_index[1:0]] = req_value;
               if (req_feature_index == NumFeat - 1)
                  decision_queue.push_back(decision_of_sample());
            end
         end
         // Compare each accepted result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (decision_queue.size() == 0) begin
               $error("decision: unexpected result %0d", rsp_decision);
               fail_count++;
            end else begin
               logic signed [31:0] want;
               want = decision_queue.pop_front();
               if (rsp_decision !== want) begin
                  $error("decision: expected %0d, actual %0d", want, rsp_decision);
                  fail_count++;
               end
            end
         end
      end
      pending = decision_queue.size();
   end

   final begin
   end
endmodule

/* tb/tb_svm_rbf_decision_value_core.sv */
module tb_svm_rbf_decision_value_core
   import svm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [2:0] AddrGamma   = 3'd0;
   localparam logic [2:0] AddrSvCount = 3'd4;
   localparam int CycleLimit = 2000000;
   localparam int PhaseItems = 85;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_type;
   logic [5:0]         req_vector_index;
   logic [3:0]         req_feature_index;
   logic signed [15:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_decision;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;
   int                 fail_count;
   int                 pending;
   int                 cycles;
   logic               calm;
   logic [15:0]        gamma_set [7] = '{16'd3277, 16'd1, 16'd65535, 16'd0, 16'd200,
                                         16'd3277, 16'd20000};
   logic [6:0]         count_set [7] = '{7'd64, 7'd1, 7'd64, 7'd0, 7'd127, 7'd17,
                                         7'd40};

   svm_rbf_decision_value_core dut (.*);

   svm_rbf_decision_value_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_SV_FEAT;
      req_vector_index = '0;
      req_feature_index = '0;
      req_value = '0;
      rsp_ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cycles = 0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Calm stretches without any idling, one in every four blocks of the cycle count
   assign calm = ((cycles / 4096) % 4) == 3;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_ready <= calm || ($urandom_range(99) >= 22);
      if (cycles > CycleLimit) begin
         $display("svm_rbf_decision_value_core verification failed");
         $finish;
      end
   end

   // Send one request, with an occasional gap in front
   task automatic send_request(input logic [1:0] kind, input logic [5:0] vi,
                               input logic [3:0] fi, input logic [15:0] val);
      if (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_vector_index <= vi;
      req_feature_index <= fi;
      req_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Drop valid and let the block drain before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic send_sample();
      for (int j = 0; j < 4; j++)
         send_request(REQ_SAMPLE, 6'($urandom), 4'(j), 16'($urandom));
   endtask

   // One random step: whole samples most often, some loads, some noise
   task automatic random_step();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)
         send_sample();
      else if (pick < 65)
         send_request(REQ_SV_FEAT, 6'($urandom), 4'($urandom_range(4, 0) == 4 ?
                      $urandom_range(15, 4) : $urandom_range(3, 0)), 16'($urandom));
      else if (pick < 80)
         send_request(REQ_COEF, 6'($urandom), 4'($urandom), 16'($urandom));
      else if (pick < 88)
         send_request(REQ_SAMPLE, 6'($urandom), 4'($urandom), 16'($urandom));
      else if (pick < 93)
         send_request(REQ_UNUSED, 6'($urandom), 4'($urandom), 16'($urandom));
      else
         send_request(REQ_SAMPLE, 6'($urandom), 4'd3, 16'($urandom));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every store entry; vectors 0 and 1 and their weights at the extremes
      for (int v = 0; v < 64; v++) begin
         for (int j = 0; j < 4; j++)
            send_request(REQ_SV_FEAT, 6'(v), 4'(j), v == 0 ? 16'h7FFF :
                         v == 1 ? 16'h8000 : 16'($urandom));
         send_request(REQ_COEF, 6'(v), 4'($urandom), v == 0 ? 16'h7FFF :
                      v == 1 ? 16'h8000 : 16'($urandom));
      end

      // Directed samples: extremes, zero, ignored requests
      for (int j = 0; j < 4; j++)
         send_request(REQ_SAMPLE, 6'd63, 4'(j), 16'h8000);
      for (int j = 0; j < 4; j++)
         send_request(REQ_SAMPLE, 6'd0, 4'(j), 16'h7FFF);
      for (int j = 0; j < 4; j++)
         send_request(REQ_SAMPLE, 6'd0, 4'(j), 16'h0000);
      send_request(REQ_UNUSED, 6'd5, 4'd3, 16'h1234);
      send_request(REQ_SAMPLE, 6'd0, 4'd15, 16'h1111);
      send_request(REQ_SV_FEAT, 6'd2, 4'd9, 16'h2222);
      // Partial sample: only the last feature changes
      send_request(REQ_SAMPLE, 6'd0, 4'd3, 16'hFF00);
      send_sample();

      // Random phases across register settings
      for (int ph = 0; ph < 7; ph++) begin
         wait_idle();
         write_register(AddrGamma, ph == 6 ? 32'($urandom) : 32'(gamma_set[ph]));
         write_register(AddrSvCount, 32'(count_set[ph]));
         for (int n = 0; n < PhaseItems; n++)
            random_step();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("svm_rbf_decision_value_core verification clean");
      else
         $display("svm_rbf_decision_value_core verification failed");
      $finish;
   end
endmodule
